>>> rtl/core/itrd_pkg.sv
// Shared constants and the digit-to-ASCII mapping for the radix digit converter.
package itrd_pkg;

  localparam int NUMBER_WIDTH_DEF = 31;

  // Quotient bits the divider resolves per cycle.
  localparam int DIV_BITS = 8;

  localparam int DIGIT_W = 6;
  localparam int RADIX_W = 6;
  localparam int CHAR_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

  localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT     = 6'd10;
  localparam logic [CHAR_W-1:0]  ASCII_DIGIT_BASE  = 7'd48;
  localparam logic [CHAR_W-1:0]  ASCII_LETTER_BASE = 7'd55;
  localparam logic [CHAR_W-1:0]  CHAR_TERMINATOR   = 7'd0;

  // 0..9 -> '0'..'9', 10..35 -> 'A'..'Z'
  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] base;
    base = (d < DECIMAL_LIMIT) ? ASCII_DIGIT_BASE : ASCII_LETTER_BASE;
    return base + {1'b0, d};
  endfunction

endpackage

>>> rtl/core/integer_to_radix_digits.sv
// Top level: converts a non-negative integer to ASCII digits in radix 2..36.
// Input channel (in_valid_i / in_stall_o) carries number_i and radix_i. A
// transaction is taken only while the block is idle; in_stall_o stays high
// for the whole conversion.
// Output channel (out_valid_o / out_stall_i) carries character_o, last_o and
// bad_radix_o. Digits come most significant first, then a zero terminator
// with last_o set. A zero number gives the terminator alone. A radix outside
// 2..36 gives one transaction: character 0, last_o and bad_radix_o set.
// Each digit is one pass through the shared divider, which resolves 8
// quotient bits a cycle; the next division is then chained on the quotient.
// Digits leave at one per cycle while the receiver does not stall.
// A stall on the output holds the current transaction in the output
// register and freezes the digit readout; nothing is dropped.
// The last output register is separate from the input side, so a new number
// is accepted while the terminator still waits to be taken.
// Reset (rst_ni low, asynchronous) returns to idle with no output pending;
// the digit store is not cleared since every digit is written before read.
module integer_to_radix_digits #(
  parameter int NUMBER_WIDTH = itrd_pkg::NUMBER_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [NUMBER_WIDTH-1:0]       number_i,
  input  logic [itrd_pkg::RADIX_W-1:0]  radix_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [itrd_pkg::CHAR_W-1:0]   character_o,
  output logic                          last_o,
  output logic                          bad_radix_o
);

  localparam int CW = $clog2(NUMBER_WIDTH + 1);  // digit count
  localparam int AW = $clog2(NUMBER_WIDTH);      // digit store address

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_READ,
    ST_EMIT,
    ST_TERM
  } state_e;

  state_e                         state_q;
  logic [CW-1:0]                  cnt_q;
  logic [itrd_pkg::RADIX_W-1:0]   radix_q;
  logic                           bad_q;
  logic                           out_valid_q;
  logic [itrd_pkg::CHAR_W-1:0]    char_q;
  logic                           last_q;
  logic                           bad_out_q;

  logic                           in_acc;
  logic                           radix_bad;
  logic                           out_free;
  logic                           out_load;
  logic                           div_start;
  logic                           div_done;
  logic [NUMBER_WIDTH-1:0]        div_dividend;
  logic [itrd_pkg::RADIX_W-1:0]   div_radix;
  logic [NUMBER_WIDTH-1:0]        div_quot;
  logic [itrd_pkg::DIGIT_W-1:0]   div_rem;
  logic                           wr_en;
  logic                           rd_en;
  logic [CW-1:0]                  rd_idx;
  logic [itrd_pkg::DIGIT_W-1:0]   rd_data;
  logic                           load_digit;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign radix_bad  = (radix_i < itrd_pkg::RADIX_MIN) || (radix_i > itrd_pkg::RADIX_MAX);
  assign out_free   = !out_valid_q || !out_stall_i;
  // Output register takes a new transaction (digit or terminator).
  assign out_load   = out_free && ((state_q == ST_EMIT) || (state_q == ST_TERM));

  // First divide starts straight from the input; later ones chain on the quotient.
  assign div_start    = (in_acc && !radix_bad && (number_i != '0)) ||
                        ((state_q == ST_DIVIDE) && div_done && (div_quot != '0));
  assign div_dividend = (state_q == ST_IDLE) ? number_i : div_quot;
  assign div_radix    = (state_q == ST_IDLE) ? radix_i : radix_q;

  assign wr_en = (state_q == ST_DIVIDE) && div_done;

  // Readout runs top digit down; next address is prefetched as each digit leaves.
  assign load_digit = (state_q == ST_EMIT) && out_free;
  assign rd_en      = (state_q == ST_READ) || (load_digit && (cnt_q > CW'(1)));
  assign rd_idx     = cnt_q - ((state_q == ST_EMIT) ? CW'(2) : CW'(1));

  itrd_divider #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .radix_i     (div_radix),
    .done_o      (div_done),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  itrd_digit_ram #(
    .DEPTH(NUMBER_WIDTH)
  ) u_digit_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (cnt_q[AW-1:0]),
    .wr_data_i (div_rem),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_idx[AW-1:0]),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      radix_q     <= '0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
      char_q      <= '0;
      last_q      <= 1'b0;
      bad_out_q   <= 1'b0;
    end else begin
      // Valid holds while stalled, drops once taken, rises on a new load.
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            radix_q <= radix_i;
            bad_q   <= radix_bad;
            cnt_q   <= '0;
            state_q <= (radix_bad || (number_i == '0)) ? ST_TERM : ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          if (div_done) begin
            cnt_q <= cnt_q + CW'(1);
            if (div_quot == '0) begin
              state_q <= ST_READ;
            end
          end
        end
        ST_READ: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            char_q      <= itrd_pkg::digit_to_char(rd_data);
            last_q      <= 1'b0;
            bad_out_q   <= 1'b0;
            cnt_q       <= cnt_q - CW'(1);
            if (cnt_q == CW'(1)) begin
              state_q <= ST_TERM;
            end
          end
        end
        ST_TERM: begin
          if (out_free) begin
            char_q      <= itrd_pkg::CHAR_TERMINATOR;
            last_q      <= 1'b1;
            bad_out_q   <= bad_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;
  assign bad_radix_o = bad_out_q;

  // A bad-radix transaction is always a lone terminator.
  a_bad_is_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bad_radix_o) |-> (last_o && (character_o == itrd_pkg::CHAR_TERMINATOR)))
    else $error("bad radix flag on a non-terminator transaction");

  // Digit transactions never carry the terminator code.
  a_digit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> (character_o != itrd_pkg::CHAR_TERMINATOR))
    else $error("digit transaction carries a zero character");

  // Digit count never exceeds the store depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(NUMBER_WIDTH))
    else $error("digit count beyond store depth");

  // The divider only finishes while the sequencer waits for it.
  a_done_in_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIVIDE))
    else $error("divider done outside the divide phase");

  // Leaving the divide phase always happens with at least one digit stored.
  a_emit_has_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> (cnt_q != '0))
    else $error("readout started with no digits");

endmodule

>>> rtl/core/itrd_divider.sv
// Iterative divider by a small radix: several restoring steps per cycle.
module itrd_divider #(
  parameter int NUMBER_WIDTH = itrd_pkg::NUMBER_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [NUMBER_WIDTH-1:0]       dividend_i,
  input  logic [itrd_pkg::RADIX_W-1:0]  radix_i,
  output logic                          done_o,
  output logic [NUMBER_WIDTH-1:0]       quotient_o,
  output logic [itrd_pkg::DIGIT_W-1:0]  remainder_o
);

  localparam int Steps = (NUMBER_WIDTH + itrd_pkg::DIV_BITS - 1) / itrd_pkg::DIV_BITS;
  localparam int PadW  = Steps * itrd_pkg::DIV_BITS;
  localparam int SW    = $clog2(Steps + 1);

  logic [PadW-1:0]                 shift_q, shift_d;
  logic [itrd_pkg::DIGIT_W-1:0]    rem_q, rem_d;
  logic [itrd_pkg::RADIX_W-1:0]    radix_q;
  logic [SW-1:0]                   step_q;
  logic                            busy_q;
  logic                            done_q;

  // One cycle's worth of shift-and-subtract; the remainder stays below the radix.
  always_comb begin
    logic [itrd_pkg::DIGIT_W:0] trial;
    rem_d   = rem_q;
    shift_d = shift_q;
    trial   = '0;
    for (int i = 0; i < itrd_pkg::DIV_BITS; i++) begin
      trial   = {rem_d, shift_d[PadW-1]};
      shift_d = {shift_d[PadW-2:0], 1'b0};
      if (trial >= {1'b0, radix_q}) begin
        trial      = trial - {1'b0, radix_q};
        shift_d[0] = 1'b1;
      end
      rem_d = trial[itrd_pkg::DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      step_q  <= '0;
      shift_q <= '0;
      rem_q   <= '0;
      radix_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        shift_q <= PadW'(dividend_i);
        rem_q   <= '0;
        radix_q <= radix_i;
        step_q  <= SW'(Steps);
        busy_q  <= 1'b1;
      end else if (busy_q) begin
        shift_q <= shift_d;
        rem_q   <= rem_d;
        step_q  <= step_q - SW'(1);
        if (step_q == SW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = shift_q[NUMBER_WIDTH-1:0];
  assign remainder_o = rem_q;

endmodule

>>> rtl/core/itrd_digit_ram.sv
// Digit store: one write port, one registered read port.
module itrd_digit_ram #(
  parameter int DEPTH = itrd_pkg::NUMBER_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]      wr_addr_i,
  input  logic [itrd_pkg::DIGIT_W-1:0]  wr_data_i,
  input  logic                          rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr_i,
  output logic [itrd_pkg::DIGIT_W-1:0]  rd_data_o
);

  logic [itrd_pkg::DIGIT_W-1:0] mem_q [DEPTH];
  logic [itrd_pkg::DIGIT_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> tb/radix_digits_checker.sv
// Scoreboard for the radix digit converter: predicts and checks every output transaction.
module radix_digits_checker #(
  parameter int NUMBER_WIDTH = itrd_pkg::NUMBER_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [NUMBER_WIDTH-1:0]       number_i,
  input  logic [itrd_pkg::RADIX_W-1:0]  radix_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [itrd_pkg::CHAR_W-1:0]   character_i,
  input  logic                          last_i,
  input  logic                          bad_radix_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            conv_count_o,
  output int                            char_count_o,
  output int                            bad_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [itrd_pkg::CHAR_W-1:0] ch;
    logic                        is_last;
    logic                        bad_radix;
  } char_result_t;

  char_result_t expected_chars[$];

  // Pushes the characters one conversion should produce, MSD first.
  function automatic void predict_digits(input logic [NUMBER_WIDTH-1:0] value,
                                         input logic [itrd_pkg::RADIX_W-1:0] base);
    logic [NUMBER_WIDTH-1:0]        quotient;
    logic [itrd_pkg::DIGIT_W-1:0]   digits [NUMBER_WIDTH];
    logic [itrd_pkg::CHAR_W-1:0]    c;
    int                             n;
    if (base < itrd_pkg::RADIX_MIN || base > itrd_pkg::RADIX_MAX) begin
      expected_chars.push_back('{ch: itrd_pkg::CHAR_TERMINATOR, is_last: 1'b1,
                                 bad_radix: 1'b1});
      bad_count_o++;
      return;
    end
    quotient = value;
    n = 0;
    while (quotient != 0 && n < NUMBER_WIDTH) begin
      digits[n] = itrd_pkg::DIGIT_W'(quotient % base);
      quotient  = quotient / base;
      n++;
    end
    while (n > 0) begin
      n--;
      if (digits[n] < itrd_pkg::DECIMAL_LIMIT)
        c = itrd_pkg::ASCII_DIGIT_BASE + itrd_pkg::CHAR_W'(digits[n]);
      else
        c = itrd_pkg::ASCII_LETTER_BASE + itrd_pkg::CHAR_W'(digits[n]);
      expected_chars.push_back('{ch: c, is_last: 1'b0, bad_radix: 1'b0});
    end
    expected_chars.push_back('{ch: itrd_pkg::CHAR_TERMINATOR, is_last: 1'b1,
                               bad_radix: 1'b0});
  endfunction

  function automatic void note_failure(input string what);
    if (fail_count_o < 10) $display("checker: %s", what);
    fail_count_o++;
  endfunction

  // Output side is checked before the input side so a result can never be
  // matched against an item taken on the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    char_result_t want;
    if (!rst_ni) begin
      expected_chars.delete();
      fail_count_o = 0;
      pending_o    = 0;
      conv_count_o = 0;
      char_count_o = 0;
      bad_count_o  = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        char_count_o++;
        if (expected_chars.size() == 0) begin
          note_failure($sformatf("unexpected output char=%0d last=%0b bad_radix=%0b",
                                 character_i, last_i, bad_radix_i));
        end else begin
          want = expected_chars.pop_front();
          if (character_i !== want.ch || last_i !== want.is_last ||
              bad_radix_i !== want.bad_radix) begin
            note_failure($sformatf(
              "output %0d: expected char=%0d last=%0b bad_radix=%0b, got char=%0d last=%0b bad_radix=%0b",
              char_count_o, want.ch, want.is_last, want.bad_radix,
              character_i, last_i, bad_radix_i));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        conv_count_o++;
        predict_digits(number_i, radix_i);
      end
      pending_o = expected_chars.size();
    end
  end

endmodule

>>> tb/tb.sv
// Testbench top: stimulus, handshake pacing and verdict for the radix digit converter.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NW           = itrd_pkg::NUMBER_WIDTH_DEF;
  localparam int RW           = itrd_pkg::RADIX_W;
  localparam int RANDOM_ITEMS = 110;
  // Long receiver hold-off; the converter fills up and stalls its input.
  localparam int HOLD_CYCLES  = 400;
  // The worst conversion gives 31 digits in radix 2; the tail after the last
  // expected character gives a margin for stray outputs.
  localparam int DRAIN_CYCLES = 200;
  // Cycles without any transaction before the run is declared hung. Covers
  // the hold-off plus a full radix-2 conversion several times over.
  localparam int IDLE_LIMIT   = 3000;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  logic [NW-1:0]                 number_i    = '0;
  logic [RW-1:0]                 radix_i     = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [itrd_pkg::CHAR_W-1:0]   character_o;
  logic                          last_o;
  logic                          bad_radix_o;

  int fail_count;
  int pending;
  int conv_count;
  int char_count;
  int bad_count;
  int idle_cycles = 0;

  // Pacing controls shared by the sender and the receiver processes.
  bit steady   = 1'b0;  // no idling on either side
  bit hold_req = 1'b0;  // receiver starts its long hold-off

  integer_to_radix_digits #(
    .NUMBER_WIDTH(NW)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .number_i    (number_i),
    .radix_i     (radix_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o),
    .bad_radix_o (bad_radix_o)
  );

  radix_digits_checker #(
    .NUMBER_WIDTH(NW)
  ) u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .number_i     (number_i),
    .radix_i      (radix_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .character_i  (character_o),
    .last_i       (last_o),
    .bad_radix_i  (bad_radix_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .conv_count_o (conv_count),
    .char_count_o (char_count),
    .bad_count_o  (bad_count)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hang detector: any accepted transaction on either channel resets it.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stalls about 15% of cycles, none during the steady
  // stretch, and one long hold-off once the sender asks for it. The sender
  // keeps offering items meanwhile, so the converter backs up into its input.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (steady) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < 15);
      end
    end
  end

  // Offers one conversion and holds it until taken. Payload only moves after
  // acceptance; valid stays high straight into the next item unless a gap is
  // drawn here.
  task automatic send_item(input logic [NW-1:0] value, input logic [RW-1:0] base);
    in_valid_i <= 1'b1;
    number_i   <= value;
    radix_i    <= base;
    do @(posedge clk_i); while (in_stall_o);
    if (!steady && $urandom_range(0, 99) < 15) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  initial begin
    int            i;
    int            nbits;
    int            pick;
    logic [NW-1:0] value;
    logic [RW-1:0] base;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero input, full-width values, digit/letter boundaries, both
    // ends of the legal radix range and radixes on both sides of it.
    send_item('0, 6'd10);
    send_item({NW{1'b1}}, itrd_pkg::RADIX_MIN);     // longest output: 31 ones + terminator
    send_item({NW{1'b1}}, itrd_pkg::RADIX_MAX);
    send_item({NW{1'b1}}, 6'd16);
    send_item(NW'(1) << (NW - 1), itrd_pkg::RADIX_MIN);
    send_item(NW'(1), itrd_pkg::RADIX_MIN);
    send_item(NW'(35), itrd_pkg::RADIX_MAX);        // single 'Z'
    send_item(NW'(36), itrd_pkg::RADIX_MAX);        // "10"
    send_item(NW'(10), 6'd11);            // single 'A'
    send_item(NW'(9), 6'd10);             // single '9'
    send_item(NW'(255), 6'd16);
    send_item(NW'(2), 6'd3);
    send_item(NW'(1234567890), 6'd10);
    send_item(NW'(64), 6'd8);
    send_item('0, itrd_pkg::RADIX_MAX);
    send_item('0, itrd_pkg::RADIX_MIN);
    // Bad radix, with zero and nonzero numbers
    send_item(NW'(5), 6'd0);
    send_item(NW'(5), 6'd1);
    send_item({NW{1'b1}}, 6'd37);
    send_item('0, 6'd63);
    send_item(NW'(123), 6'd40);

    // Random: numbers of random bit length so every digit count shows up,
    // a few zeros, and about 15% bad radixes.
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      steady = (i >= 70 && i < 100);
      if (i == 30) hold_req = 1'b1;
      nbits = $urandom_range(1, NW);
      value = NW'($urandom()) & ({NW{1'b1}} >> (NW - nbits));
      if ($urandom_range(0, 19) == 0) value = '0;
      if ($urandom_range(0, 99) < 15) begin
        pick = $urandom_range(0, 29);
        base = (pick < 2) ? RW'(pick) : RW'(pick + 35);
      end else begin
        base = RW'($urandom_range(itrd_pkg::RADIX_MIN, itrd_pkg::RADIX_MAX));
      end
      send_item(value, base);
    end
    steady = 1'b0;

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("tb: %0d conversions (%0d with out-of-range radix), %0d characters compared",
             conv_count, bad_count, char_count);
    $display("tb: random stalls on both sides, a %0d-cycle output hold-off, a no-idle stretch",
             HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
